// ----- src/spmfd_pkg.sv -----
// Shared types, constants and helpers for the static pixel mask block.
package spmfd_pkg;

    localparam int MAX_PIXELS_DEF = 262144;

    localparam int CH_W      = 8;
    localparam int PIX_W     = 3 * CH_W;
    localparam int THR_W     = 8;
    localparam int FSZ_W     = 19;
    localparam int CFG_W     = 19;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STILL_THRESHOLD  = 1'b0,
        REG_PIXELS_PER_FRAME = 1'b1
    } t_cfg_reg;

    localparam logic [THR_W-1:0] THR_RESET = 8'd225;
    localparam logic [FSZ_W-1:0] FSZ_RESET = 19'd262144;

    // Gray conversion in Q14: (1868*B + 9617*G + 4899*R + 8192) >> 14
    localparam int PROD_W     = 22;
    localparam int GRAY_SHIFT = 14;
    localparam logic [PROD_W-1:0] GRAY_B     = 22'd1868;
    localparam logic [PROD_W-1:0] GRAY_G     = 22'd9617;
    localparam logic [PROD_W-1:0] GRAY_R     = 22'd4899;
    localparam logic [PROD_W-1:0] GRAY_ROUND = 22'd8192;
    localparam logic [CH_W-1:0]   GRAY_MAX   = 8'd255;

    typedef struct packed {
        logic last;
        logic primed;
    } t_item_flags;

    function automatic logic [CH_W-1:0] sub_clamp(input logic [CH_W-1:0] a,
                                                  input logic [CH_W-1:0] b);
        return (a > b) ? a - b : '0;
    endfunction

endpackage

// ----- src/spmfd_ctrl.sv -----
// Configuration registers, raster position counter and first-frame flag.
module spmfd_ctrl #(
    parameter int MAX_PIXELS = spmfd_pkg::MAX_PIXELS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [spmfd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [spmfd_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                                i_accept,
    output logic [((MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1)-1:0] o_pos,
    output spmfd_pkg::t_item_flags              o_flags,
    output logic [spmfd_pkg::THR_W-1:0]         o_threshold
);

    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int CW = (AW + 1 > spmfd_pkg::FSZ_W) ? AW + 1 : spmfd_pkg::FSZ_W;

    logic [spmfd_pkg::THR_W-1:0] r_thr;
    logic [spmfd_pkg::FSZ_W-1:0] r_fsz;
    logic [AW-1:0]               r_pos;
    logic                        r_primed;

    logic [spmfd_pkg::FSZ_W-1:0] w_size;
    logic [AW:0]                 w_next;
    logic                        w_last;

    // zero-sized frame acts as one pixel; oversize saturates at the store depth
    assign w_size = (r_fsz == '0) ? spmfd_pkg::FSZ_W'(1) : r_fsz;
    assign w_next = {1'b0, r_pos} + (AW + 1)'(1);
    assign w_last = (CW'(w_next) >= CW'(w_size)) || (CW'(w_next) >= CW'(MAX_PIXELS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= spmfd_pkg::THR_RESET;
            r_fsz <= spmfd_pkg::FSZ_RESET;
        end else if (i_cfg_we) begin
            unique case (spmfd_pkg::t_cfg_reg'(i_cfg_idx))
                spmfd_pkg::REG_STILL_THRESHOLD:  r_thr <= i_cfg_data[spmfd_pkg::THR_W-1:0];
                spmfd_pkg::REG_PIXELS_PER_FRAME: r_fsz <= i_cfg_data[spmfd_pkg::FSZ_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_primed <= 1'b0;
        end else if (i_accept) begin
            r_pos <= w_last ? '0 : w_next[AW-1:0];
            if (w_last) begin
                r_primed <= 1'b1;
            end
        end
    end

    assign o_pos          = r_pos;
    assign o_flags.last   = w_last;
    assign o_flags.primed = r_primed;
    assign o_threshold    = r_thr;

    a_wrap_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && w_last |=> r_pos == '0)
        else $error("position did not wrap after last pixel");

    a_step_by_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && !w_last |=> r_pos == $past(w_next[AW-1:0]))
        else $error("position did not advance by one");

    a_primed_at_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_primed) |-> $past(i_accept && w_last))
        else $error("primed set outside a frame end");

endmodule

// ----- src/spmfd_frame_store.sv -----
// Previous-frame pixel store: read old value and write new value at one address.
module spmfd_frame_store #(
    parameter int MAX_PIXELS = spmfd_pkg::MAX_PIXELS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [((MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1)-1:0] i_addr,
    input  logic [spmfd_pkg::PIX_W-1:0]       i_wdata,
    output logic [spmfd_pkg::PIX_W-1:0]       o_rdata
);

    logic [spmfd_pkg::PIX_W-1:0] r_mem [MAX_PIXELS];
    logic [spmfd_pkg::PIX_W-1:0] r_rdata;

    // read-before-write: the item sees the pixel of the previous frame
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata        <= r_mem[i_addr];
            r_mem[i_addr]  <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/spmfd_mask_store.sv -----
// Sticky static mask store, one bit per pixel, separate read and write ports.
module spmfd_mask_store #(
    parameter int MAX_PIXELS = spmfd_pkg::MAX_PIXELS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rd_en,
    input  logic [((MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1)-1:0] i_rd_addr,
    output logic                              o_rd_data,
    input  logic                              i_wr_en,
    input  logic [((MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1)-1:0] i_wr_addr,
    input  logic                              i_wr_data
);

    logic r_mem [MAX_PIXELS];
    logic r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/static_pixel_mask_by_frame_difference_core.sv -----
// Static pixel mask core. Takes one BGR pixel per clock in raster order and
// returns one result per pixel, at a sustained rate of one pixel per clock while
// the output does not stall. Each pixel does a read-modify-write of its own entry
// in the frame store (at accept) and in the mask store (two stages later); a
// same-address write from the item one stage ahead is forwarded, so frames as
// short as one pixel run at full rate. The four stages advance together: a stall
// on the output holds the whole pipeline and the input stall. There is no
// clearing pass after reset: the first frame only loads the frame store and writes
// every mask bit static, and all its pixels report static. The user must write
// registers only while the block is idle; the block itself does not enforce this.
module static_pixel_mask_by_frame_difference_core #(
    parameter int MAX_PIXELS = spmfd_pkg::MAX_PIXELS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [spmfd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [spmfd_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [spmfd_pkg::CH_W-1:0]      i_blue,
    input  logic [spmfd_pkg::CH_W-1:0]      i_green,
    input  logic [spmfd_pkg::CH_W-1:0]      i_red,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_is_static,
    output logic                            o_end_of_frame
);

    localparam int AW   = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int CH_W = spmfd_pkg::CH_W;
    localparam int PW   = spmfd_pkg::PROD_W;

    logic                          w_en;
    logic                          w_accept;
    logic [AW-1:0]                 w_pos;
    spmfd_pkg::t_item_flags        w_flags;
    logic [spmfd_pkg::THR_W-1:0]   w_thr;
    logic [spmfd_pkg::PIX_W-1:0]   w_prev;
    logic                          w_mask_rd;

    // stage 1: pixel and stored previous pixel
    logic                          r_s1_valid;
    logic [spmfd_pkg::PIX_W-1:0]   r_s1_pix;
    logic [AW-1:0]                 r_s1_pos;
    spmfd_pkg::t_item_flags        r_s1_flags;
    // stage 2: clamped channel differences
    logic                          r_s2_valid;
    logic [CH_W-1:0]               r_s2_db, r_s2_dg, r_s2_dr;
    logic [AW-1:0]                 r_s2_pos;
    spmfd_pkg::t_item_flags        r_s2_flags;
    // stage 3: weighted products, mask bit read
    logic                          r_s3_valid;
    logic [PW-1:0]                 r_s3_pb, r_s3_pg, r_s3_pr;
    logic [AW-1:0]                 r_s3_pos;
    spmfd_pkg::t_item_flags        r_s3_flags;
    // stage 4: result
    logic                          r_s4_valid;
    logic                          r_s4_static;
    logic                          r_s4_last;
    logic                          r_s4_primed;
    logic [AW-1:0]                 r_s4_pos;

    logic [PW-1:0]                 w_sum;
    logic [CH_W-1:0]               w_gray;
    logic [CH_W-1:0]               w_inv;
    logic                          w_pass;
    logic                          w_mask_old;
    logic                          w_static;

    assign o_stall  = r_s4_valid && i_stall;
    assign w_en     = !o_stall;
    assign w_accept = i_valid && w_en;

    spmfd_ctrl #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (w_accept),
        .o_pos       (w_pos),
        .o_flags     (w_flags),
        .o_threshold (w_thr)
    );

    spmfd_frame_store #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_frame_store (
        .i_clk   (i_clk),
        .i_en    (w_accept),
        .i_addr  (w_pos),
        .i_wdata ({i_red, i_green, i_blue}),
        .o_rdata (w_prev)
    );

    spmfd_mask_store #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_mask_store (
        .i_clk     (i_clk),
        .i_rd_en   (w_en && r_s2_valid),
        .i_rd_addr (r_s2_pos),
        .o_rd_data (w_mask_rd),
        .i_wr_en   (w_en && r_s3_valid),
        .i_wr_addr (r_s3_pos),
        .i_wr_data (w_static)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_pix    <= {i_red, i_green, i_blue};
            r_s1_pos    <= w_pos;
            r_s1_flags  <= w_flags;

            r_s2_db     <= spmfd_pkg::sub_clamp(r_s1_pix[CH_W-1:0], w_prev[CH_W-1:0]);
            r_s2_dg     <= spmfd_pkg::sub_clamp(r_s1_pix[2*CH_W-1:CH_W],
                                                w_prev[2*CH_W-1:CH_W]);
            r_s2_dr     <= spmfd_pkg::sub_clamp(r_s1_pix[3*CH_W-1:2*CH_W],
                                                w_prev[3*CH_W-1:2*CH_W]);
            r_s2_pos    <= r_s1_pos;
            r_s2_flags  <= r_s1_flags;

            r_s3_pb     <= PW'(r_s2_db) * spmfd_pkg::GRAY_B;
            r_s3_pg     <= PW'(r_s2_dg) * spmfd_pkg::GRAY_G;
            r_s3_pr     <= PW'(r_s2_dr) * spmfd_pkg::GRAY_R;
            r_s3_pos    <= r_s2_pos;
            r_s3_flags  <= r_s2_flags;

            r_s4_static <= w_static;
            r_s4_last   <= r_s3_flags.last;
            r_s4_primed <= r_s3_flags.primed;
            r_s4_pos    <= r_s3_pos;
        end
    end

    // sum fits in 22 bits for 8-bit differences
    assign w_sum  = r_s3_pb + r_s3_pg + r_s3_pr + spmfd_pkg::GRAY_ROUND;
    assign w_gray = w_sum[spmfd_pkg::GRAY_SHIFT +: CH_W];
    assign w_inv  = spmfd_pkg::GRAY_MAX - w_gray;
    assign w_pass = w_inv > w_thr;

    // stage 4 holds the item that wrote the mask on the edge this one read it
    assign w_mask_old = (r_s4_valid && (r_s4_pos == r_s3_pos)) ? r_s4_static : w_mask_rd;
    assign w_static   = r_s3_flags.primed ? (w_mask_old && w_pass) : 1'b1;

    assign o_valid        = r_s4_valid;
    assign o_is_static    = r_s4_static;
    assign o_end_of_frame = r_s4_last;

    a_first_frame_static: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !r_s4_primed |-> o_is_static)
        else $error("pixel of the loading frame reported as changed");

    a_mask_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && r_s3_valid && r_s3_flags.primed && !w_mask_old |=> !o_is_static)
        else $error("cleared mask bit came back");

endmodule
